// ===== sv/bbns_pkg.sv =====
package bbns_pkg;

	localparam int BUFFER_BYTES_DEF = 256;
	localparam int WIN_BITS         = 40;
	localparam int WIN_BYTES        = 5;
	localparam int MAX_RW_BITS      = 32;

	typedef enum logic [3:0] {
		K_LOAD_BYTE  = 4'd0,
		K_START      = 4'd1,
		K_CLEAR      = 4'd2,
		K_READ_BITS  = 4'd3,
		K_SKIP       = 4'd4,
		K_READ_NS    = 4'd5,
		K_WRITE_BITS = 4'd6,
		K_WRITE_NS   = 4'd7,
		K_READ_BYTE  = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_BAD   = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_CLR,
		S_FETCH,
		S_MERGE,
		S_STORE,
		S_FIN
	} state_t;

	typedef struct packed {
		logic take;
		logic plan;
		logic cnt_rst;
		logic fetch;
		logic merge;
		logic store;
		logic wipe;
		logic load_byte;
		logic look_byte;
		logic finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  bad;
		logic  ns_short;
		logic  fetch_last;
		logic  store_last;
		logic  wipe_last;
		logic  out_free;
	} sts_t;

	function automatic logic [4:0] bit_length(input logic [30:0] n);
		logic [4:0] w;
		w = '0;
		for (int i = 0; i < 31; i++) begin
			if (n[i]) begin
				w = 5'(i + 1);
			end
		end
		return w;
	endfunction

	function automatic logic [31:0] low_mask(input logic [5:0] cnt);
		logic [32:0] m;
		m = (33'd1 << cnt) - 33'd1;
		return m[31:0];
	endfunction

endpackage

// ===== sv/bit_buffer_ns_codec.sv =====
// One item at a time. Load byte, start, skip, read byte and rejected items go from decode
// to the result; read bits and read ns fetch 5 bytes over the RAM port and then merge;
// write bits and write ns fetch 5 bytes, merge and write 5 bytes back; clear zeroes each byte.
// The result is registered once the output is free; a new item can be taken while it waits.
// After reset the byte store is zeroed one byte per cycle before the first transfer is
// taken; cursor and stream length reset to zero.
module bit_buffer_ns_codec #(
	parameter int BUFFER_BYTES = bbns_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  kind,
	input  logic        at_cursor,
	input  logic [10:0] bit_offset,
	input  logic [11:0] bit_count,
	input  logic [30:0] alphabet_size,
	input  logic [31:0] value,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  byte_data,
	input  logic [8:0]  byte_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [1:0]  status,
	output logic [11:0] cursor,
	output logic [11:0] left_bits,
	output logic [7:0]  read_byte
);

	bbns_pkg::cmd_t cmd;
	bbns_pkg::sts_t sts;

	bbns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbns_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.at_cursor     (at_cursor),
		.bit_offset    (bit_offset),
		.bit_count     (bit_count),
		.alphabet_size (alphabet_size),
		.value         (value),
		.byte_index    (byte_index),
		.byte_data     (byte_data),
		.byte_count    (byte_count),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.result_value  (result_value),
		.status        (status),
		.cursor        (cursor),
		.left_bits     (left_bits),
		.read_byte     (read_byte)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_error_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bbns_pkg::ST_OK |-> result_value == '0 && read_byte == '0)
		else $error("error result carries data");

	a_byte_only_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_byte != '0 |-> result_value == '0 && status == bbns_pkg::ST_OK)
		else $error("read byte result mixed with bit result");

endmodule

// ===== sv/bbns_ram.sv =====
module bbns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/bbns_ctrl.sv =====
module bbns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bbns_pkg::sts_t    sts,
	output bbns_pkg::cmd_t    cmd
);

	bbns_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbns_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bbns_pkg::S_INIT: begin
				cmd.wipe = 1'b1;
				if (sts.wipe_last) begin
					state_d = bbns_pkg::S_IDLE;
				end
			end
			bbns_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = bbns_pkg::S_DECODE;
				end
			end
			bbns_pkg::S_DECODE: begin
				cmd.plan    = 1'b1;
				cmd.cnt_rst = 1'b1;
				state_d     = bbns_pkg::S_FIN;
				if (!sts.bad && !sts.ns_short) begin
					case (sts.kind)
						bbns_pkg::K_LOAD_BYTE: cmd.load_byte = 1'b1;
						bbns_pkg::K_READ_BYTE: cmd.look_byte = 1'b1;
						bbns_pkg::K_CLEAR:     state_d = bbns_pkg::S_CLR;
						bbns_pkg::K_READ_BITS,
						bbns_pkg::K_READ_NS,
						bbns_pkg::K_WRITE_BITS,
						bbns_pkg::K_WRITE_NS:  state_d = bbns_pkg::S_FETCH;
						default:               state_d = bbns_pkg::S_FIN;
					endcase
				end
			end
			bbns_pkg::S_CLR: begin
				cmd.wipe = 1'b1;
				if (sts.wipe_last) begin
					state_d = bbns_pkg::S_FIN;
				end
			end
			bbns_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
				if (sts.fetch_last) begin
					state_d = bbns_pkg::S_MERGE;
				end
			end
			bbns_pkg::S_MERGE: begin
				cmd.merge   = 1'b1;
				cmd.cnt_rst = 1'b1;
				if (sts.kind == bbns_pkg::K_WRITE_BITS || sts.kind == bbns_pkg::K_WRITE_NS) begin
					state_d = bbns_pkg::S_STORE;
				end else begin
					state_d = bbns_pkg::S_FIN;
				end
			end
			bbns_pkg::S_STORE: begin
				cmd.store = 1'b1;
				if (sts.store_last) begin
					state_d = bbns_pkg::S_FIN;
				end
			end
			bbns_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = bbns_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bbns_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/bbns_dp.sv =====
module bbns_dp #(
	parameter int BUFFER_BYTES = bbns_pkg::BUFFER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bbns_pkg::cmd_t cmd,
	output bbns_pkg::sts_t sts,
	input  logic [3:0]     kind,
	input  logic           at_cursor,
	input  logic [10:0]    bit_offset,
	input  logic [11:0]    bit_count,
	input  logic [30:0]    alphabet_size,
	input  logic [31:0]    value,
	input  logic [7:0]     byte_index,
	input  logic [7:0]     byte_data,
	input  logic [8:0]     byte_count,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [31:0]    result_value,
	output logic [1:0]     status,
	output logic [11:0]    cursor,
	output logic [11:0]    left_bits,
	output logic [7:0]     read_byte
);

	localparam int AW       = $clog2(BUFFER_BYTES);
	localparam int BUF_BITS = BUFFER_BYTES * 8;
	localparam int CW       = $clog2(BUF_BITS + 1);
	localparam int PW       = (CW > 11) ? CW : 11;
	localparam int BW       = PW - 2;
	localparam int LW       = $clog2(BUFFER_BYTES + 1);
	localparam int LX       = (LW + 3 > CW) ? LW + 3 : CW;
	localparam int SW       = ((CW > 12) ? CW : 12) + 1;
	localparam int IW       = (AW > 8) ? AW : 8;
	localparam int WB       = bbns_pkg::WIN_BITS;

	bbns_pkg::kind_t kind_q;
	logic            at_cursor_q;
	logic [10:0]     bit_offset_q;
	logic [11:0]     bit_count_q;
	logic [30:0]     n_q;
	logic [31:0]     value_q;
	logic [7:0]      byte_index_q;
	logic [7:0]      byte_data_q;
	logic [8:0]      byte_count_q;

	logic [CW-1:0]   cursor_q;
	logic [LW-1:0]   len_q;
	logic [AW-1:0]   cnt_q;
	logic            out_valid_q;

	bbns_pkg::stat_t st_q, st_o_q;
	logic [31:0]     res_q, res_o_q;
	logic [7:0]      rbyte_o_q;
	logic [11:0]     adv_q;
	logic [5:0]      wcnt_q;
	logic [31:0]     wbits_q;
	logic [PW-1:0]   pos_q;
	logic [4:0]      w_q;
	logic [31:0]     m_q;
	logic [WB-1:0]   win_q;
	logic            rd_ok_q;

	logic [4:0]      w_c;
	logic [31:0]     m_c;
	logic [LX-1:0]   len8_c, left_c;
	logic            bad_c, short_c, kind_ok_c;
	logic [BW-1:0]   baddr_c;
	logic            bok_c;
	logic [IW-1:0]   idx_c;
	logic            iok_c;
	logic [5:0]      sh_c;
	logic [31:0]     wmask_c, raw_c, v_c, ns_sum_c;
	logic [WB-1:0]   clr_c, put_c;
	logic [SW-1:0]   sum_c;
	logic [CW-1:0]   cursor_next_c;
	logic [LW-1:0]   start_len_c;
	logic [4:0]      w1_c;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	bbns_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		w_c    = bbns_pkg::bit_length(n_q);
		m_c    = (32'd1 << w_c) - {1'b0, n_q};
		w1_c   = w_q - 5'd1;
		len8_c = LX'({len_q, 3'b000});
		left_c = (len8_c > LX'(cursor_q)) ? len8_c - LX'(cursor_q) : '0;

		case (kind_q)
			bbns_pkg::K_LOAD_BYTE, bbns_pkg::K_START, bbns_pkg::K_CLEAR,
			bbns_pkg::K_READ_BITS, bbns_pkg::K_SKIP, bbns_pkg::K_READ_NS,
			bbns_pkg::K_WRITE_BITS, bbns_pkg::K_WRITE_NS,
			bbns_pkg::K_READ_BYTE: kind_ok_c = 1'b1;
			default:               kind_ok_c = 1'b0;
		endcase

		bad_c = !kind_ok_c
			|| ((kind_q == bbns_pkg::K_READ_BITS || kind_q == bbns_pkg::K_WRITE_BITS)
				&& bit_count_q > 12'(bbns_pkg::MAX_RW_BITS))
			|| ((kind_q == bbns_pkg::K_READ_NS || kind_q == bbns_pkg::K_WRITE_NS)
				&& n_q == '0);
		short_c = (kind_q == bbns_pkg::K_READ_NS) && (n_q != '0)
			&& (32'(left_c) < 32'(w_c) - 32'd1);

		baddr_c = BW'(pos_q >> 3) + BW'(cnt_q[2:0]);
		bok_c   = baddr_c < BW'(BUFFER_BYTES);
		idx_c   = IW'(byte_index_q);
		iok_c   = 32'(idx_c) < 32'(BUFFER_BYTES);

		sh_c     = 6'(WB) - {3'b000, pos_q[2:0]} - wcnt_q;
		wmask_c  = bbns_pkg::low_mask(wcnt_q);
		raw_c    = 32'(win_q >> sh_c) & wmask_c;
		v_c      = {1'b0, raw_c[31:1]};
		ns_sum_c = (v_c << 1) - m_q + {31'b0, raw_c[0]};
		clr_c    = ~(WB'(wmask_c) << sh_c);
		put_c    = WB'(wbits_q) << sh_c;

		sum_c         = SW'(cursor_q) + SW'(adv_q);
		cursor_next_c = (sum_c > SW'(BUF_BITS)) ? CW'(BUF_BITS) : CW'(sum_c);
		start_len_c   = (32'(byte_count_q) > 32'(BUFFER_BYTES)) ? LW'(BUFFER_BYTES)
			: LW'(byte_count_q);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(baddr_c);
		ram_wdata = win_q[WB-1 -: 8];
		ram_re    = 1'b0;
		ram_raddr = AW'(baddr_c);
		if (cmd.wipe) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = 8'h00;
		end else if (cmd.load_byte) begin
			ram_we    = iok_c;
			ram_waddr = AW'(idx_c);
			ram_wdata = byte_data_q;
		end else if (cmd.store) begin
			ram_we = bok_c;
		end
		if (cmd.look_byte) begin
			ram_re    = iok_c;
			ram_raddr = AW'(idx_c);
		end else if (cmd.fetch) begin
			ram_re = bok_c && (cnt_q < AW'(bbns_pkg::WIN_BYTES));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_rst) begin
				cnt_q <= '0;
			end else if (cmd.fetch || cmd.store || cmd.wipe) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				case (kind_q)
					bbns_pkg::K_START: begin
						len_q    <= start_len_c;
						cursor_q <= '0;
					end
					bbns_pkg::K_CLEAR: begin
						len_q    <= LW'(BUFFER_BYTES);
						cursor_q <= '0;
					end
					default: begin
						cursor_q <= cursor_next_c;
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q       <= bbns_pkg::kind_t'(kind);
			at_cursor_q  <= at_cursor;
			bit_offset_q <= bit_offset;
			bit_count_q  <= bit_count;
			n_q          <= alphabet_size;
			value_q      <= value;
			byte_index_q <= byte_index;
			byte_data_q  <= byte_data;
			byte_count_q <= byte_count;
		end

		if (cmd.plan) begin
			st_q    <= bad_c ? bbns_pkg::ST_BAD : (short_c ? bbns_pkg::ST_SHORT : bbns_pkg::ST_OK);
			res_q   <= '0;
			w_q     <= w_c;
			m_q     <= m_c;
			wbits_q <= value_q & bbns_pkg::low_mask(bit_count_q[5:0]);
			wcnt_q  <= (kind_q == bbns_pkg::K_READ_NS) ? 6'(w_c) : bit_count_q[5:0];
			if (!at_cursor_q && (kind_q == bbns_pkg::K_WRITE_BITS
				|| kind_q == bbns_pkg::K_WRITE_NS)) begin
				pos_q <= PW'(bit_offset_q);
			end else begin
				pos_q <= PW'(cursor_q);
			end
			if (bad_c || short_c) begin
				adv_q <= '0;
			end else begin
				case (kind_q)
					bbns_pkg::K_READ_BITS,
					bbns_pkg::K_WRITE_BITS,
					bbns_pkg::K_SKIP:    adv_q <= bit_count_q;
					bbns_pkg::K_READ_NS: adv_q <= 12'(w_c) - 12'd1;
					default:             adv_q <= '0;
				endcase
			end
		end

		if (cmd.fetch) begin
			if (cnt_q == '0 && kind_q == bbns_pkg::K_WRITE_NS) begin
				if (value_q < m_q) begin
					wcnt_q  <= 6'(w1_c);
					wbits_q <= value_q & bbns_pkg::low_mask(6'(w1_c));
					adv_q   <= 12'(w1_c);
				end else begin
					wcnt_q  <= 6'(w_q);
					wbits_q <= (value_q + m_q) & bbns_pkg::low_mask(6'(w_q));
					adv_q   <= 12'(w_q);
				end
			end
			if (cnt_q != '0) begin
				win_q <= {win_q[WB-9:0], rd_ok_q ? ram_rdata : 8'h00};
			end
			rd_ok_q <= bok_c;
		end

		if (cmd.merge) begin
			case (kind_q)
				bbns_pkg::K_READ_BITS: begin
					res_q <= raw_c;
				end
				bbns_pkg::K_READ_NS: begin
					if (v_c < m_q) begin
						res_q <= v_c;
					end else if (32'(left_c) < 32'(w_q)) begin
						st_q  <= bbns_pkg::ST_SHORT;
						res_q <= '0;
					end else begin
						res_q <= ns_sum_c;
						adv_q <= 12'(w_q);
					end
				end
				bbns_pkg::K_WRITE_BITS,
				bbns_pkg::K_WRITE_NS: begin
					win_q <= (win_q & clr_c) | put_c;
				end
				default: begin
					res_q <= '0;
				end
			endcase
		end

		if (cmd.store) begin
			win_q <= win_q << 8;
		end

		if (cmd.finish) begin
			st_o_q    <= st_q;
			res_o_q   <= res_q;
			rbyte_o_q <= (kind_q == bbns_pkg::K_READ_BYTE && iok_c) ? ram_rdata : 8'h00;
		end
	end

	always_comb begin
		sts.kind       = kind_q;
		sts.bad        = bad_c;
		sts.ns_short   = short_c;
		sts.fetch_last = cnt_q == AW'(bbns_pkg::WIN_BYTES);
		sts.store_last = cnt_q == AW'(bbns_pkg::WIN_BYTES - 1);
		sts.wipe_last  = cnt_q == AW'(BUFFER_BYTES - 1);
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_o_q;
	assign status       = st_o_q;
	assign read_byte    = rbyte_o_q;
	assign cursor       = 12'(cursor_q);
	assign left_bits    = 12'(left_c);

endmodule

// ===== verif/bit_buffer_ns_codec_checker.sv =====
module bit_buffer_ns_codec_checker
	import bbns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  kind,
	input  logic        at_cursor,
	input  logic [10:0] bit_offset,
	input  logic [11:0] bit_count,
	input  logic [30:0] alphabet_size,
	input  logic [31:0] value,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  byte_data,
	input  logic [8:0]  byte_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] result_value,
	input  logic [1:0]  status,
	input  logic [11:0] cursor,
	input  logic [11:0] left_bits,
	input  logic [7:0]  read_byte,
	output int          mismatches,
	output int          outstanding,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_BYTES = BUFFER_BYTES_DEF;
	localparam int unsigned STORE_BITS  = STORE_BYTES * 8;

	typedef struct {
		logic [31:0] value;
		stat_t       status;
		logic [11:0] cursor;
		logic [11:0] left;
		logic [7:0]  rbyte;
	} outcome_t;

	logic [7:0]  shadow_mem [STORE_BYTES];
	int unsigned cur_pos;
	int unsigned len_bytes;
	outcome_t    awaiting [$];
	outcome_t    due;
	int          err_count;
	int          result_count;

	function automatic bit peek_bit(input int unsigned pos);
		if (pos >= STORE_BITS) begin
			return 1'b0;
		end
		return shadow_mem[pos / 8][7 - (pos % 8)];
	endfunction

	function automatic void poke_bit(input int unsigned pos, input bit b);
		if (pos < STORE_BITS) begin
			shadow_mem[pos / 8][7 - (pos % 8)] = b;
		end
	endfunction

	function automatic void step_cursor(input int unsigned n);
		cur_pos = (cur_pos + n > STORE_BITS) ? STORE_BITS : cur_pos + n;
	endfunction

	function automatic int unsigned bits_left();
		return (cur_pos >= len_bytes * 8) ? 0 : len_bytes * 8 - cur_pos;
	endfunction

	function automatic logic [31:0] fetch_bits(input int unsigned count);
		logic [31:0] acc;
		acc = '0;
		for (int unsigned i = 0; i < count; i++) begin
			acc = {acc[30:0], peek_bit(cur_pos + i)};
		end
		step_cursor(count);
		return acc;
	endfunction

	function automatic void store_bits(input int unsigned origin, input int unsigned count,
			input logic [31:0] bits);
		for (int unsigned i = 0; i < count; i++) begin
			poke_bit(origin + i, bits[count - 1 - i]);
		end
		step_cursor(count);
	endfunction

	function automatic int unsigned width_of(input logic [30:0] n);
		int unsigned w;
		w = 0;
		while (n != 0) begin
			n = n >> 1;
			w++;
		end
		return w;
	endfunction

	function automatic outcome_t apply_op(input logic [3:0] op, input logic at_cur,
			input logic [10:0] offs, input logic [11:0] cnt, input logic [30:0] n,
			input logic [31:0] val, input logic [7:0] idx, input logic [7:0] data,
			input logic [8:0] blen);
		outcome_t    o;
		int unsigned w;
		int unsigned origin;
		logic [31:0] v;
		logic [31:0] m;
		o.value  = '0;
		o.status = ST_OK;
		o.rbyte  = '0;
		origin   = at_cur ? cur_pos : offs;
		case (op)
			K_LOAD_BYTE: begin
				if (idx < STORE_BYTES) begin
					shadow_mem[idx] = data;
				end
			end
			K_START: begin
				len_bytes = (blen > STORE_BYTES) ? STORE_BYTES : blen;
				cur_pos   = 0;
			end
			K_CLEAR: begin
				foreach (shadow_mem[i]) begin
					shadow_mem[i] = '0;
				end
				cur_pos   = 0;
				len_bytes = STORE_BYTES;
			end
			K_READ_BITS: begin
				if (cnt > MAX_RW_BITS) begin
					o.status = ST_BAD;
				end else begin
					o.value = fetch_bits(cnt);
				end
			end
			K_SKIP: begin
				step_cursor(cnt);
			end
			K_READ_NS: begin
				if (n == 0) begin
					o.status = ST_BAD;
				end else begin
					w = width_of(n);
					if (bits_left() < w - 1) begin
						o.status = ST_SHORT;
					end else begin
						v = fetch_bits(w - 1);
						m = (32'd1 << w) - 32'(n);
						if (v < m) begin
							o.value = v;
						end else if (bits_left() < 1) begin
							o.status = ST_SHORT;
						end else begin
							o.value = (v << 1) - m + fetch_bits(1);
						end
					end
				end
			end
			K_WRITE_BITS: begin
				if (cnt > MAX_RW_BITS) begin
					o.status = ST_BAD;
				end else begin
					store_bits(origin, cnt, val);
				end
			end
			K_WRITE_NS: begin
				if (n == 0) begin
					o.status = ST_BAD;
				end else begin
					w = width_of(n);
					m = (32'd1 << w) - 32'(n);
					if (val < m) begin
						store_bits(origin, w - 1, val);
					end else begin
						store_bits(origin, w, val + m);
					end
				end
			end
			K_READ_BYTE: begin
				if (idx < STORE_BYTES) begin
					o.rbyte = shadow_mem[idx];
				end
			end
			default: begin
				o.status = ST_BAD;
			end
		endcase
		o.cursor = 12'(cur_pos);
		o.left   = 12'(bits_left());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_mem[i]) begin
				shadow_mem[i] = '0;
			end
			cur_pos      = 0;
			len_bytes    = 0;
			err_count    = 0;
			result_count = 0;
			awaiting.delete();
		end else begin
			if (in_valid && in_ready) begin
				awaiting.push_back(apply_op(kind, at_cursor, bit_offset, bit_count,
					alphabet_size, value, byte_index, byte_data, byte_count));
			end
			if (out_valid && out_ready) begin
				if (awaiting.size() == 0) begin
					err_count++;
					if (err_count <= 10) begin
						$display("%0t: result with nothing pending: value=%h status=%0d cursor=%0d",
							$time, result_value, status, cursor);
					end
				end else begin
					due = awaiting.pop_front();
					result_count++;
					if (result_value !== due.value || status !== due.status ||
							cursor !== due.cursor || left_bits !== due.left ||
							read_byte !== due.rbyte) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t: result %0d expected value=%h status=%0d cursor=%0d left=%0d byte=%h",
								$time, result_count, due.value, due.status, due.cursor, due.left,
								due.rbyte);
							$display("%0t: result %0d got      value=%h status=%0d cursor=%0d left=%0d byte=%h",
								$time, result_count, result_value, status, cursor, left_bits,
								read_byte);
						end
					end
				end
			end
		end
		mismatches   <= err_count;
		outstanding  <= awaiting.size();
		results_seen <= result_count;
	end

endmodule

// ===== verif/bit_buffer_ns_codec_tb.sv =====
module bit_buffer_ns_codec_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbns_pkg::*;

	localparam logic [3:0] KIND_LAST = 4'hF;
	localparam int RAND_PER_PHASE = 288;

	typedef struct {
		logic [3:0]  kind;
		logic        at_cursor;
		logic [10:0] bit_offset;
		logic [11:0] bit_count;
		logic [30:0] alphabet_size;
		logic [31:0] value;
		logic [7:0]  byte_index;
		logic [7:0]  byte_data;
		logic [8:0]  byte_count;
	} op_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  kind;
	logic        at_cursor;
	logic [10:0] bit_offset;
	logic [11:0] bit_count;
	logic [30:0] alphabet_size;
	logic [31:0] value;
	logic [7:0]  byte_index;
	logic [7:0]  byte_data;
	logic [8:0]  byte_count;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result_value;
	logic [1:0]  status;
	logic [11:0] cursor;
	logic [11:0] left_bits;
	logic [7:0]  read_byte;

	int mismatches;
	int outstanding;
	int results_seen;

	int idle_pct;
	int stall_pct;
	int sent;
	int ns_reads;
	int ns_writes;
	int clears;
	int rejects;

	bit_buffer_ns_codec DUT (.*);

	bit_buffer_ns_codec_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic op_t op_of(input logic [3:0] k);
		op_t o;
		o.kind          = k;
		o.at_cursor     = 1'b0;
		o.bit_offset    = '0;
		o.bit_count     = '0;
		o.alphabet_size = '0;
		o.value         = '0;
		o.byte_index    = '0;
		o.byte_data     = '0;
		o.byte_count    = '0;
		return o;
	endfunction

	function automatic logic [11:0] rw_count();
		if ($urandom_range(6) != 0) begin
			return 12'($urandom_range(MAX_RW_BITS));
		end
		return 12'($urandom_range(4095, MAX_RW_BITS + 1));
	endfunction

	function automatic logic [30:0] ns_alphabet();
		int unsigned w;
		case ($urandom_range(9))
			0: return '0;
			1: return 31'(32'd1 << $urandom_range(30));
			default: begin
				w = ($urandom_range(3) == 0) ? $urandom_range(31, 1) : $urandom_range(8, 1);
				return 31'($urandom_range((32'd1 << w) - 1, 32'd1 << (w - 1)));
			end
		endcase
	endfunction

	function automatic op_t random_op();
		op_t         o;
		int unsigned pick;
		o.kind          = 4'($urandom);
		o.at_cursor     = 1'($urandom);
		o.bit_offset    = 11'($urandom);
		o.bit_count     = 12'($urandom);
		o.alphabet_size = 31'($urandom);
		o.value         = $urandom;
		o.byte_index    = 8'($urandom);
		o.byte_data     = 8'($urandom);
		o.byte_count    = 9'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			o.kind = K_LOAD_BYTE;
		end else if (pick < 14) begin
			o.kind = K_START;
			if ($urandom_range(3) != 0) begin
				o.byte_count = 9'($urandom_range(BUFFER_BYTES_DEF));
			end
		end else if (pick < 16) begin
			o.kind = K_CLEAR;
		end else if (pick < 31) begin
			o.kind      = K_READ_BITS;
			o.bit_count = rw_count();
		end else if (pick < 38) begin
			o.kind = K_SKIP;
			if ($urandom_range(4) != 0) begin
				o.bit_count = 12'($urandom_range(64));
			end
		end else if (pick < 56) begin
			o.kind          = K_READ_NS;
			o.alphabet_size = ns_alphabet();
		end else if (pick < 71) begin
			o.kind      = K_WRITE_BITS;
			o.bit_count = rw_count();
		end else if (pick < 88) begin
			o.kind          = K_WRITE_NS;
			o.alphabet_size = ns_alphabet();
			if (o.alphabet_size != 0 && $urandom_range(4) != 0) begin
				o.value = $urandom_range(32'(o.alphabet_size) - 1, 0);
			end
		end else if (pick < 96) begin
			o.kind = K_READ_BYTE;
		end else begin
			o.kind = 4'($urandom_range(KIND_LAST, K_READ_BYTE + 1));
		end
		return o;
	endfunction

	task automatic send_op(input op_t o);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= o.kind;
		at_cursor     <= o.at_cursor;
		bit_offset    <= o.bit_offset;
		bit_count     <= o.bit_count;
		alphabet_size <= o.alphabet_size;
		value         <= o.value;
		byte_index    <= o.byte_index;
		byte_data     <= o.byte_data;
		byte_count    <= o.byte_count;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		case (o.kind)
			K_READ_NS:  ns_reads++;
			K_WRITE_NS: ns_writes++;
			K_CLEAR:    clears++;
			default: begin
				if (o.kind > K_READ_BYTE) begin
					rejects++;
				end
			end
		endcase
	endtask

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		op_t o;
		int  idle_by_phase [4];
		int  stall_by_phase [4];
		idle_by_phase  = '{0, 68, 0, 33};
		stall_by_phase = '{0, 0, 68, 33};
		idle_pct      = 0;
		stall_pct     = 0;
		sent          = 0;
		ns_reads      = 0;
		ns_writes     = 0;
		clears        = 0;
		rejects       = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = '0;
		at_cursor     = 1'b0;
		bit_offset    = '0;
		bit_count     = '0;
		alphabet_size = '0;
		value         = '0;
		byte_index    = '0;
		byte_data     = '0;
		byte_count    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		o = op_of(K_READ_BYTE);
		send_op(o);
		o = op_of(K_LOAD_BYTE); o.byte_data = 8'hFF;
		send_op(o);
		o = op_of(K_LOAD_BYTE); o.byte_index = 8'hFF; o.byte_data = 8'hA5;
		send_op(o);
		o = op_of(K_START);
		send_op(o);
		o = op_of(K_READ_NS); o.alphabet_size = 31'd5;
		send_op(o);
		o = op_of(K_START); o.byte_count = 9'd1;
		send_op(o);
		o = op_of(K_SKIP); o.bit_count = 12'd6;
		send_op(o);
		o = op_of(K_READ_NS); o.alphabet_size = 31'd5;
		send_op(o);
		o = op_of(K_START); o.byte_count = 9'h1FF;
		send_op(o);
		o = op_of(K_READ_BITS); o.bit_count = 12'd32;
		send_op(o);
		o = op_of(K_READ_BITS);
		send_op(o);
		o = op_of(K_READ_BITS); o.bit_count = 12'd33;
		send_op(o);
		o = op_of(K_READ_NS);
		send_op(o);
		o = op_of(K_READ_NS); o.alphabet_size = 31'd1;
		send_op(o);
		o = op_of(K_READ_NS); o.alphabet_size = 31'h7FFF_FFFF;
		send_op(o);
		o = op_of(K_WRITE_BITS); o.bit_offset = 11'd2040; o.bit_count = 12'd32;
		o.value = 32'hFFFF_FFFF;
		send_op(o);
		o = op_of(K_WRITE_BITS); o.bit_count = 12'd33; o.value = 32'h1234_5678;
		send_op(o);
		o = op_of(K_WRITE_NS); o.at_cursor = 1'b1; o.alphabet_size = 31'd5; o.value = 32'd4;
		send_op(o);
		o = op_of(K_WRITE_NS); o.bit_offset = 11'd100; o.alphabet_size = 31'd7;
		o.value = 32'hFFFF_FFFF;
		send_op(o);
		o = op_of(K_WRITE_NS); o.value = 32'd3;
		send_op(o);
		o = op_of(K_SKIP); o.bit_count = 12'hFFF;
		send_op(o);
		o = op_of(K_READ_BITS); o.bit_count = 12'd32;
		send_op(o);
		o = op_of(K_READ_BYTE); o.byte_index = 8'hFF;
		send_op(o);
		o = op_of(KIND_LAST);
		send_op(o);
		o = op_of(K_CLEAR);
		send_op(o);
		o = op_of(K_READ_BYTE);
		send_op(o);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = idle_by_phase[phase];
			stall_pct = stall_by_phase[phase];
			repeat (RAND_PER_PHASE) send_op(random_op());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("%0d transfers over four handshake phases, %0d results compared", sent,
			results_seen);
		$display("ns reads %0d, ns writes %0d, clears %0d, rejected kinds %0d", ns_reads,
			ns_writes, clears, rejects);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
